>>> src/mtcd_pkg.sv
package mtcd_pkg;

    // field and register widths
    localparam int TIMER_BITS = 16;
    localparam int CLK_W      = 28;
    localparam int PRESC_W    = 16;
    localparam int TEETH_W    = 8;
    localparam int MISS_W     = 4;
    localparam int IVL_W      = 32;
    localparam int SPEED_W    = 27;
    localparam int ANGLE_W    = 9;
    localparam int ENG_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // derived widths
    localparam int MUL_W     = TIMER_BITS + PRESC_W + 1;
    localparam int EXT_W     = (MUL_W > IVL_W) ? MUL_W : IVL_W + 1;
    localparam int GAP_W     = IVL_W + 5;
    localparam int DEN_W     = TEETH_W + 1;
    localparam int ANG_NUM_W = TEETH_W + 9;

    // shared divider: dividend and quotient width, divisor width
    localparam int DIV_W     = CLK_W;
    localparam int DIV_DEN_W = IVL_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [TIMER_BITS-1:0] TIMER_TOP   = '1;
    localparam logic [IVL_W-1:0]      IVL_MAX     = '1;
    localparam logic [SPEED_W-1:0]    SPEED_MAX   = '1;
    localparam logic [ANG_NUM_W-1:0]  DEG_PER_REV = ANG_NUM_W'(360);
    localparam logic [ENG_W-1:0]      HALF_OFFSET = ENG_W'(360);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEETH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING   = 2'd3;

    // configuration reset values
    localparam logic [CLK_W-1:0]   RST_CLOCK_HZ  = CLK_W'(84000000);
    localparam logic [PRESC_W-1:0] RST_PRESCALER = '0;
    localparam logic [TEETH_W-1:0] RST_TEETH     = TEETH_W'(17);
    localparam logic [MISS_W-1:0]  RST_MISSING   = MISS_W'(1);

    // request kinds
    localparam logic REQ_CAPTURE = 1'b0;
    localparam logic REQ_ANGLE   = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [TIMER_BITS-1:0] capture_time;
        logic                  cam_half;
    } t_req;

    typedef struct packed {
        logic [IVL_W-1:0]   tooth_interval;
        logic [SPEED_W-1:0] raw_speed_hz;
        logic [SPEED_W-1:0] filtered_speed_hz;
        logic               gap_detected;
        logic               tooth_jump_error;
        logic [TEETH_W-1:0] tooth_number;
        logic [ANGLE_W-1:0] rev_angle;
        logic [ENG_W-1:0]   cycle_angle;
    } t_rsp;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAP_MUL,
        S_CAP_SCALE,
        S_CAP_DIV1,
        S_CAP_DIV2,
        S_CAP_UPD,
        S_ANG_INC,
        S_ANG_DIV,
        S_ANG_WAIT,
        S_FIN
    } t_state;

endpackage

>>> src/missing_tooth_crank_decoder_core.sv
// channel   | direction | handshake                  | payload
// request   | in        | i_valid / o_stall          | i_req  (t_req)
// result    | out       | o_valid / i_stall          | o_rsp  (t_rsp)
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// o_stall stays high while a capture, an angle update or a capture with a zero interval
// is worked on; captures and angle updates share one 28-step divider
// one request at a time: o_stall is high from acceptance until the result is loaded
// the result register holds a finished result while i_stall is high, and a new
// result waits in the final state until the register is free
// reset is synchronous, active low, and loads the config defaults and clears state
module missing_tooth_crank_decoder_core import mtcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_req                  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer
    t_state r_state;
    t_state n_state;

    // configuration
    logic [CLK_W-1:0]   r_clock_hz;
    logic [CLK_W-1:0]   n_clock_hz;
    logic [PRESC_W-1:0] r_prescaler;
    logic [PRESC_W-1:0] n_prescaler;
    logic [TEETH_W-1:0] r_teeth;
    logic [TEETH_W-1:0] n_teeth;
    logic [MISS_W-1:0]  r_missing;
    logic [MISS_W-1:0]  n_missing;

    // decoder state
    logic [TIMER_BITS-1:0] r_last;
    logic [TIMER_BITS-1:0] n_last;
    logic [IVL_W-1:0]      r_prev;
    logic [IVL_W-1:0]      n_prev;
    logic [SPEED_W-1:0]    r_raw;
    logic [SPEED_W-1:0]    n_raw;
    logic [SPEED_W-1:0]    r_filt;
    logic [SPEED_W-1:0]    n_filt;
    logic [TEETH_W-1:0]    r_count;
    logic [TEETH_W-1:0]    n_count;
    logic                  r_jump;
    logic                  n_jump;
    logic [ANGLE_W-1:0]    r_angle;
    logic [ANGLE_W-1:0]    n_angle;
    logic [ENG_W-1:0]      r_engine;
    logic [ENG_W-1:0]      n_engine;

    // working registers of one request
    logic [TIMER_BITS-1:0] r_cap;
    logic [TIMER_BITS-1:0] n_cap;
    logic                  r_half;
    logic                  n_half;
    logic [IVL_W-1:0]      r_ivl;
    logic [IVL_W-1:0]      n_ivl;
    logic [GAP_W-1:0]      r_ivl10;
    logic [GAP_W-1:0]      n_ivl10;
    logic [GAP_W-1:0]      r_prev17;
    logic [GAP_W-1:0]      n_prev17;
    logic                  r_gap;
    logic                  n_gap;

    // result register
    t_rsp r_out;
    t_rsp n_out;
    logic r_out_valid;
    logic n_out_valid;

    // datapath helpers
    logic [TIMER_BITS-1:0] delta;
    logic [PRESC_W:0]      presc_p1;
    logic [MUL_W-1:0]      prod;
    logic [EXT_W-1:0]      prod_ext;
    logic [IVL_W-1:0]      ivl_sat;
    logic [SPEED_W-1:0]    quo_sat;
    logic [DEN_W-1:0]      ang_den;
    logic [TEETH_W-1:0]    count_m1;
    logic [ANG_NUM_W-1:0]  ang_num;
    logic [ENG_W-1:0]      half_add;
    logic [SPEED_W:0]      filt_sum;

    t_div_cmd div_cmd;
    t_div_rsp div_rsp;

    mtcd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    // tick count since the last edge, with the timer wrap
    assign delta = (r_cap > r_last) ? (r_cap - r_last) : (TIMER_TOP - r_last + r_cap);

    // scale by prescaler plus one, clamp to the interval width
    assign presc_p1 = {1'b0, r_prescaler} + 1'b1;
    assign prod     = MUL_W'(delta) * MUL_W'(presc_p1);
    assign prod_ext = EXT_W'(prod);
    assign ivl_sat  = (prod_ext > EXT_W'(IVL_MAX)) ? IVL_MAX : prod_ext[IVL_W-1:0];

    // speed clamp on the divider quotient
    assign quo_sat = (div_rsp.quotient > DIV_W'(SPEED_MAX)) ? SPEED_MAX
                                                            : div_rsp.quotient[SPEED_W-1:0];

    // angle operands
    assign ang_den  = DEN_W'(r_teeth) + DEN_W'(r_missing);
    assign count_m1 = r_count - 1'b1;
    assign ang_num  = ANG_NUM_W'(count_m1) * DEG_PER_REV;
    assign half_add = r_half ? HALF_OFFSET : '0;

    // running mean of filtered and new raw speed
    assign filt_sum = {1'b0, r_filt} + {1'b0, r_raw};

    always_comb begin
        n_state     = r_state;
        n_clock_hz  = r_clock_hz;
        n_prescaler = r_prescaler;
        n_teeth     = r_teeth;
        n_missing   = r_missing;
        n_last      = r_last;
        n_prev      = r_prev;
        n_raw       = r_raw;
        n_filt      = r_filt;
        n_count     = r_count;
        n_jump      = r_jump;
        n_angle     = r_angle;
        n_engine    = r_engine;
        n_cap       = r_cap;
        n_half      = r_half;
        n_ivl       = r_ivl;
        n_ivl10     = r_ivl10;
        n_prev17    = r_prev17;
        n_gap       = r_gap;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_cmd     = '0;

        // the user must write config only while the block is idle; the block does not enforce this
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLOCK_HZ:  n_clock_hz  = i_cfg_data[CLK_W-1:0];
                CFG_PRESCALER: n_prescaler = i_cfg_data[PRESC_W-1:0];
                CFG_TEETH:     n_teeth     = i_cfg_data[TEETH_W-1:0];
                CFG_MISSING:   n_missing   = i_cfg_data[MISS_W-1:0];
            endcase
        end

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cap   = i_req.capture_time;
                    n_half  = i_req.cam_half;
                    n_state = (i_req.req_type == REQ_ANGLE) ? S_ANG_INC : S_CAP_MUL;
                end
            end
            S_CAP_MUL: begin
                n_ivl   = ivl_sat;
                n_last  = r_cap;
                n_state = S_CAP_SCALE;
            end
            S_CAP_SCALE: begin
                // 10 * interval against 17 * previous: the 1.7 ratio in integers
                n_ivl10  = (GAP_W'(r_ivl) << 3) + (GAP_W'(r_ivl) << 1);
                n_prev17 = (GAP_W'(r_prev) << 4) + GAP_W'(r_prev);
                if (r_ivl == '0) begin
                    n_raw   = '0;
                    n_state = S_CAP_UPD;
                end else begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = DIV_W'(r_clock_hz);
                    div_cmd.divisor  = r_ivl;
                    n_state          = S_CAP_DIV1;
                end
            end
            S_CAP_DIV1: begin
                // clock / interval, then / (teeth + 1)
                if (div_rsp.done) begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = div_rsp.quotient;
                    div_cmd.divisor  = DIV_DEN_W'(r_teeth) + DIV_DEN_W'(1);
                    n_state          = S_CAP_DIV2;
                end
            end
            S_CAP_DIV2: begin
                if (div_rsp.done) begin
                    n_raw   = quo_sat;
                    n_state = S_CAP_UPD;
                end
            end
            S_CAP_UPD: begin
                n_gap  = (r_ivl10 >= r_prev17);
                n_prev = r_ivl;
                if (r_ivl10 >= r_prev17) begin
                    // gap: hold the filter, check for a lost or extra tooth
                    n_jump  = ((DEN_W'(r_count) + DEN_W'(1)) >= DEN_W'(r_teeth));
                    n_count = TEETH_W'(1);
                end else begin
                    n_filt = filt_sum[SPEED_W:1];
                end
                n_state = S_FIN;
            end
            S_ANG_INC: begin
                n_gap   = 1'b0;
                n_count = (r_count < r_teeth) ? (r_count + 1'b1) : TEETH_W'(1);
                n_state = S_ANG_DIV;
            end
            S_ANG_DIV: begin
                if (ang_den == '0) begin
                    n_angle  = '0;
                    n_engine = half_add;
                    n_state  = S_FIN;
                end else begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = DIV_W'(ang_num);
                    div_cmd.divisor  = DIV_DEN_W'(ang_den);
                    n_state          = S_ANG_WAIT;
                end
            end
            S_ANG_WAIT: begin
                if (div_rsp.done) begin
                    n_angle  = div_rsp.quotient[ANGLE_W-1:0];
                    n_engine = ENG_W'(div_rsp.quotient[ANGLE_W-1:0]) + half_add;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                // load the result once the register is free
                if (!r_out_valid || !i_stall) begin
                    n_out.tooth_interval    = r_prev;
                    n_out.raw_speed_hz      = r_raw;
                    n_out.filtered_speed_hz = r_filt;
                    n_out.gap_detected      = r_gap;
                    n_out.tooth_jump_error  = r_jump;
                    n_out.tooth_number      = r_count;
                    n_out.rev_angle         = r_angle;
                    n_out.cycle_angle       = r_engine;
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock_hz  <= RST_CLOCK_HZ;
            r_prescaler <= RST_PRESCALER;
            r_teeth     <= RST_TEETH;
            r_missing   <= RST_MISSING;
            r_last      <= '0;
            r_prev      <= '0;
            r_raw       <= '0;
            r_filt      <= '0;
            r_count     <= '0;
            r_jump      <= 1'b0;
            r_angle     <= '0;
            r_engine    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clock_hz  <= n_clock_hz;
            r_prescaler <= n_prescaler;
            r_teeth     <= n_teeth;
            r_missing   <= n_missing;
            r_last      <= n_last;
            r_prev      <= n_prev;
            r_raw       <= n_raw;
            r_filt      <= n_filt;
            r_count     <= n_count;
            r_jump      <= n_jump;
            r_angle     <= n_angle;
            r_engine    <= n_engine;
            r_out_valid <= n_out_valid;
        end
        r_cap    <= n_cap;
        r_half   <= n_half;
        r_ivl    <= n_ivl;
        r_ivl10  <= n_ivl10;
        r_prev17 <= n_prev17;
        r_gap    <= n_gap;
        r_out    <= n_out;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> src/mtcd_divider.sv
module mtcd_divider import mtcd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 n_busy;
    logic                 r_done;
    logic                 n_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] n_den;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     n_quo;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    // one quotient bit per cycle while busy, dividend shifts out as quotient shifts in
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (r_busy) begin
            n_rem = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_W - 1);
            n_rem  = '0;
            n_den  = i_cmd.divisor;
            n_quo  = i_cmd.dividend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> test/missing_tooth_crank_decoder_core_test.sv
`timescale 1ns / 100ps

module missing_tooth_crank_decoder_core_test;
    import mtcd_pkg::*;

    // clock period is 10 ns, so the limit is about 10 ms of simulated time
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall_mode;

    // dut ports, all inputs driven to known values from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_req                  i_req = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    missing_tooth_crank_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow copy of the decoder registers, as they stand after reset
    logic [CLK_W-1:0]   exp_clock_hz  = RST_CLOCK_HZ;
    logic [PRESC_W-1:0] exp_prescaler = RST_PRESCALER;
    logic [TEETH_W-1:0] exp_teeth     = RST_TEETH;
    logic [MISS_W-1:0]  exp_missing   = RST_MISSING;

    // shadow copy of the decoder state
    logic [TIMER_BITS-1:0] last_edge  = '0;
    logic [IVL_W-1:0]      prev_ticks = '0;
    logic [SPEED_W-1:0]    raw_hz     = '0;
    logic [SPEED_W-1:0]    filt_hz    = '0;
    logic [TEETH_W-1:0]    tooth_pos  = '0;
    logic                  jump_seen  = 1'b0;
    logic [ANGLE_W-1:0]    crank_deg  = '0;
    logic [ENG_W-1:0]      engine_deg = '0;

    // readings predicted for accepted requests, oldest first
    t_rsp awaited_readings[$];
    int   bad_readings = 0;
    int   cycle_count = 0;

    // sender burst shaping and receiver stall control
    int          gap_max = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          hold_cycles = 0;
    int          stall_tick = 0;

    // wheel position used by the well-formed sequences
    logic [TIMER_BITS-1:0] wheel_time = '0;

    function automatic t_req make_req(input logic kind, input logic [TIMER_BITS-1:0] stamp,
                                      input logic half);
        t_req r;
        r.req_type     = kind;
        r.capture_time = stamp;
        r.cam_half     = half;
        return r;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CLOCK_HZ:  exp_clock_hz  = data[CLK_W-1:0];
            CFG_PRESCALER: exp_prescaler = data[PRESC_W-1:0];
            CFG_TEETH:     exp_teeth     = data[TEETH_W-1:0];
            CFG_MISSING:   exp_missing   = data[MISS_W-1:0];
            default: ;
        endcase
    endfunction

    // advances the shadow state by one request and returns the reading it yields
    function automatic t_rsp predict_reading(input t_req r);
        logic [63:0]          ticks;
        logic [63:0]          hz;
        logic [ANG_NUM_W-1:0] deg_num;
        logic [9:0]           den;
        logic                 gap;
        t_rsp                 res;
        gap = 1'b0;
        if (r.req_type == REQ_CAPTURE) begin
            // wrapped timer difference; equal stamps count as a full wrap
            if (r.capture_time > last_edge)
                ticks = 64'(r.capture_time) - 64'(last_edge);
            else
                ticks = 64'(TIMER_TOP) - 64'(last_edge) + 64'(r.capture_time);
            ticks = ticks * (64'(exp_prescaler) + 64'd1);
            if (ticks > 64'(IVL_MAX))
                ticks = 64'(IVL_MAX);
            if (ticks == 64'd0)
                hz = 64'd0;
            else
                hz = 64'(exp_clock_hz) / ticks / (64'(exp_teeth) + 64'd1);
            if (hz > 64'(SPEED_MAX))
                hz = 64'(SPEED_MAX);
            raw_hz = hz[SPEED_W-1:0];
            last_edge = r.capture_time;
            // 1.7 ratio in integer form, zero history always counts as the gap
            gap = (64'd10 * ticks) >= (64'd17 * 64'(prev_ticks));
            prev_ticks = ticks[IVL_W-1:0];
            if (gap) begin
                jump_seen = ({1'b0, tooth_pos} + 9'd1) >= {1'b0, exp_teeth};
                tooth_pos = TEETH_W'(1);
            end else begin
                filt_hz = SPEED_W'((28'(filt_hz) + 28'(raw_hz)) >> 1);
            end
        end else begin
            if (tooth_pos < exp_teeth)
                tooth_pos = tooth_pos + TEETH_W'(1);
            else
                tooth_pos = TEETH_W'(1);
            den = 10'(exp_teeth) + 10'(exp_missing);
            if (den == 10'd0) begin
                crank_deg = '0;
            end else begin
                deg_num = DEG_PER_REV * (ANG_NUM_W'(tooth_pos) - ANG_NUM_W'(1));
                crank_deg = ANGLE_W'(deg_num / ANG_NUM_W'(den));
            end
            engine_deg = ENG_W'(crank_deg) + (r.cam_half ? HALF_OFFSET : ENG_W'(0));
        end
        res.tooth_interval    = prev_ticks;
        res.raw_speed_hz      = raw_hz;
        res.filtered_speed_hz = filt_hz;
        res.gap_detected      = gap;
        res.tooth_jump_error  = jump_seen;
        res.tooth_number      = tooth_pos;
        res.rev_angle         = crank_deg;
        res.cycle_angle       = engine_deg;
        return res;
    endfunction

    // receiver side: long hold-off first, otherwise the selected stall pattern
    always @(posedge i_clk) begin
        stall_tick = stall_tick + 1;
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_RANDOM:  i_stall <= ($urandom_range(0, 99) < 30);
                STALL_PATTERN: i_stall <= ((stall_tick % 11) < 4);
                STALL_HEAVY:   i_stall <= ($urandom_range(0, 99) < 75);
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // compare every accepted reading with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_readings.size() == 0) begin
                bad_readings = bad_readings + 1;
                if (bad_readings <= MAX_REPORTS)
                    $display("unexpected reading at cycle %0d: %h", cycle_count, o_rsp);
            end else begin
                want = awaited_readings.pop_front();
                if (o_rsp.tooth_interval !== want.tooth_interval
                        || o_rsp.raw_speed_hz !== want.raw_speed_hz
                        || o_rsp.filtered_speed_hz !== want.filtered_speed_hz
                        || o_rsp.gap_detected !== want.gap_detected
                        || o_rsp.tooth_jump_error !== want.tooth_jump_error
                        || o_rsp.tooth_number !== want.tooth_number
                        || o_rsp.rev_angle !== want.rev_angle
                        || o_rsp.cycle_angle !== want.cycle_angle) begin
                    bad_readings = bad_readings + 1;
                    if (bad_readings <= MAX_REPORTS) begin
                        $display("reading mismatch at cycle %0d", cycle_count);
                        $display("  expected ivl=%0d raw=%0d filt=%0d gap=%0b jump=%0b",
                                 want.tooth_interval, want.raw_speed_hz,
                                 want.filtered_speed_hz, want.gap_detected,
                                 want.tooth_jump_error);
                        $display("           tooth=%0d rev=%0d cyc=%0d",
                                 want.tooth_number, want.rev_angle, want.cycle_angle);
                        $display("  actual   ivl=%0d raw=%0d filt=%0d gap=%0b jump=%0b",
                                 o_rsp.tooth_interval, o_rsp.raw_speed_hz,
                                 o_rsp.filtered_speed_hz, o_rsp.gap_detected,
                                 o_rsp.tooth_jump_error);
                        $display("           tooth=%0d rev=%0d cyc=%0d",
                                 o_rsp.tooth_number, o_rsp.rev_angle, o_rsp.cycle_angle);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one request: optional idle gap between bursts, then hold until accepted
    task automatic send_req(input t_req r);
        if (gap_max != 0 && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left != 0)
            burst_left = burst_left - 1;
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_stall);
        awaited_readings.push_back(predict_reading(r));
    endtask

    // stop offering and wait for every outstanding reading
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // all four registers in one pass, only while the decoder is idle
    task automatic write_config(input logic [CLK_W-1:0] clk_hz,
                                input logic [PRESC_W-1:0] presc,
                                input logic [TEETH_W-1:0] teeth,
                                input logic [MISS_W-1:0] miss);
        logic [CFG_IDX_W-1:0]  reg_order [4];
        logic [CFG_DATA_W-1:0] reg_value [4];
        reg_order[0] = CFG_CLOCK_HZ;
        reg_order[1] = CFG_PRESCALER;
        reg_order[2] = CFG_TEETH;
        reg_order[3] = CFG_MISSING;
        reg_value[0] = CFG_DATA_W'(clk_hz);
        reg_value[1] = CFG_DATA_W'(presc);
        reg_value[2] = CFG_DATA_W'(teeth);
        reg_value[3] = CFG_DATA_W'(miss);
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_order[k];
            i_cfg_data <= reg_value[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_config(reg_order[k], reg_value[k]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_req random_req();
        return make_req(1'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    // well-formed wheel: capture plus angle update per tooth, long interval at the gap,
    // some dropped teeth, random noise and occasional full drains
    task automatic run_wheel(input int n_items, input int noise_pct);
        int   teeth;
        int   miss;
        int   period;
        int   period_top;
        int   step;
        int   pos;
        int   sent;
        logic half;
        teeth = (exp_teeth == 0) ? 1 : int'(exp_teeth);
        miss = int'(exp_missing);
        period_top = 60000 / (miss + 1);
        period = $urandom_range(8, period_top);
        pos = $urandom_range(0, teeth - 1);
        half = 1'($urandom);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_req(random_req());
                sent = sent + 1;
            end else begin
                step = (pos == 0) ? period * (miss + 1) : period;
                step = step + int'($urandom_range(0, period / 8)) - period / 16;
                // a missed edge looks like a stretched tooth
                if ($urandom_range(0, 99) < 3)
                    step = step + period;
                wheel_time = wheel_time + TIMER_BITS'(step);
                send_req(make_req(REQ_CAPTURE, wheel_time, half));
                send_req(make_req(REQ_ANGLE, 16'($urandom), half));
                sent = sent + 2;
                pos = pos + 1;
                if (pos >= teeth) begin
                    pos = 0;
                    half = ~half;
                end
                // slow drift in engine speed
                period = period + int'($urandom_range(0, 8)) - 4;
                if (period < 8)
                    period = 8;
                if (period > period_top)
                    period = period_top;
            end
            if ($urandom_range(0, 99) < 1)
                wait_idle();
        end
    endtask

    // timer wrap, equal stamps, zero interval and both cam halves at reset settings
    task automatic test_directed_edges();
        gap_max = 0;
        stall_mode = STALL_NONE;
        send_req(make_req(REQ_ANGLE, 16'h0000, 1'b0));
        send_req(make_req(REQ_CAPTURE, 16'h0000, 1'b0));
        send_req(make_req(REQ_CAPTURE, 16'hFFFF, 1'b0));
        send_req(make_req(REQ_CAPTURE, 16'h0000, 1'b1));
        send_req(make_req(REQ_CAPTURE, 16'h0000, 1'b0));
        send_req(make_req(REQ_CAPTURE, 16'h0001, 1'b0));
        send_req(make_req(REQ_CAPTURE, 16'h0001, 1'b1));
        send_req(make_req(REQ_ANGLE, 16'hFFFF, 1'b1));
        send_req(make_req(REQ_CAPTURE, 16'h8000, 1'b0));
        send_req(make_req(REQ_CAPTURE, 16'h8001, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'h5555, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'hAAAA, 1'b1));
    endtask

    // register extremes: saturated speed, zero angle divisor, largest interval
    task automatic test_config_extremes();
        write_config('1, '0, '0, '0);
        send_req(make_req(REQ_CAPTURE, last_edge + 16'd1, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'h0000, 1'b1));
        send_req(make_req(REQ_CAPTURE, last_edge + 16'd2, 1'b0));
        write_config(CLK_W'(1), '1, '1, '1);
        send_req(make_req(REQ_CAPTURE, last_edge, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'h0000, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'h0000, 1'b1));
    endtask

    // jump flag set when the gap comes late, cleared when it comes early
    task automatic test_jump_flag();
        write_config(RST_CLOCK_HZ, '0, TEETH_W'(3), MISS_W'(1));
        send_req(make_req(REQ_CAPTURE, last_edge + 16'd100, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'h0000, 1'b0));
        send_req(make_req(REQ_CAPTURE, last_edge + 16'd100, 1'b0));
        send_req(make_req(REQ_ANGLE, 16'h0000, 1'b0));
        send_req(make_req(REQ_CAPTURE, last_edge + 16'd400, 1'b0));
        send_req(make_req(REQ_CAPTURE, last_edge + 16'd2000, 1'b1));
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_receiver_hold();
        wait_idle();
        gap_max = 0;
        stall_mode = STALL_NONE;
        hold_cycles = 600;
        repeat (6) send_req(random_req());
        wait_idle();
    endtask

    task automatic run_phase(input int n_items, input int gap, input t_stall_mode mode,
                             input int noise_pct);
        gap_max = gap;
        stall_mode = mode;
        run_wheel(n_items, noise_pct);
    endtask

    // several settings, extremes among them; most teeth counts kept small
    task automatic test_random_wheel();
        write_config(RST_CLOCK_HZ, RST_PRESCALER, RST_TEETH, RST_MISSING);
        run_phase(150, 0, STALL_NONE, 10);
        write_config(CLK_W'($urandom_range(1, 250000000)), PRESC_W'($urandom_range(0, 7)),
                     TEETH_W'($urandom_range(2, 40)), MISS_W'($urandom_range(0, 3)));
        run_phase(150, 20, STALL_RANDOM, 15);
        write_config('1, '1, '1, '1);
        run_phase(80, 8, STALL_PATTERN, 20);
        write_config(CLK_W'(1), '0, TEETH_W'(1), '0);
        run_phase(80, 40, STALL_HEAVY, 15);
        write_config('1, '0, '0, '0);
        run_phase(80, 5, STALL_RANDOM, 25);
        repeat (3) begin
            write_config(CLK_W'($urandom), PRESC_W'($urandom_range(0, 3)),
                         TEETH_W'($urandom_range(1, 60)), MISS_W'($urandom));
            run_phase(110, $urandom_range(0, 30), t_stall_mode'($urandom_range(0, 3)), 15);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_config_extremes();
        test_jump_flag();
        test_receiver_hold();
        test_random_wheel();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (bad_readings == 0 && awaited_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> missing_tooth_crank_decoder_core.f
src/mtcd_pkg.sv
src/mtcd_divider.sv
src/missing_tooth_crank_decoder_core.sv
test/missing_tooth_crank_decoder_core_test.sv
